>>> rtl/core/tpt_pkg.sv
// Shared types and constants for the page table translator.
`timescale 1ns / 1ps
`default_nettype none

package tpt_pkg;

    localparam int TLB_DEPTH_DEF       = 64;
    localparam int TABLE_MEM_WORDS_DEF = 16384;
    localparam int DIR_BASE_W          = 4;
    localparam int WALK_W              = 30;
    localparam int VALID_BIT           = 0;

    typedef enum logic [1:0] {
        REQ_TRANSLATE = 2'd0,
        REQ_WRITE     = 2'd1,
        REQ_INSERT    = 2'd2,
        REQ_INVAL     = 2'd3
    } tpt_req_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] virt_addr;
        logic [31:0] insert_phys_addr;
        logic [13:0] mem_word_addr;
        logic [31:0] mem_data;
    } tpt_in_t;

    typedef struct packed {
        logic        tlb_hit;
        logic        translated;
        logic [31:0] phys_addr;
    } tpt_out_t;

    typedef struct packed {
        tpt_req_t    kind;
        logic [19:0] vpn;
        logic [11:0] offset;
        logic [19:0] frame;
        logic [31:0] data;
    } tpt_op_t;

endpackage

`default_nettype wire

>>> rtl/core/tpt_queue.sv
// Two-entry queue between the request front end and the execution back end.
`timescale 1ns / 1ps
`default_nettype none

module tpt_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rstn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  pop_valid,
    output logic [WIDTH-1:0]      pop_data
);

    localparam logic [1:0] QDEPTH = 2'd2;

    logic [WIDTH-1:0] ent_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full      = (count_reg == QDEPTH);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = ent_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tpt_front.sv
// Front end: accepts requests, classifies them and works out TLB slot and table addresses.
`timescale 1ns / 1ps
`default_nettype none

module tpt_front #(
    parameter int TLB_DEPTH       = tpt_pkg::TLB_DEPTH_DEF,
    parameter int TABLE_MEM_WORDS = tpt_pkg::TABLE_MEM_WORDS_DEF,
    localparam int SW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1,
    localparam int AW = $clog2(TABLE_MEM_WORDS)
) (
    input  wire logic                            clk,
    input  wire logic                            rstn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tpt_pkg::DIR_BASE_W-1:0]  cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire tpt_pkg::tpt_in_t                s_data,
    input  wire logic                            clearing,
    input  wire logic                            full,
    output logic                                 push,
    output tpt_pkg::tpt_op_t                     push_op,
    output logic [SW-1:0]                        push_slot,
    output logic [AW-1:0]                        push_addr
);

    localparam int         SL          = $clog2(TLB_DEPTH);
    localparam int         SLOT_SHIFT  = 20 + SL;
    localparam logic [63:0] SLOT_RCP_W = ((64'd1 << SLOT_SHIFT) + 64'(TLB_DEPTH) - 64'd1)
                                         / 64'(TLB_DEPTH);
    localparam logic [21:0] SLOT_RCP   = SLOT_RCP_W[21:0];
    localparam int         QS          = (SL == 0) ? 20 : 21 - SL;
    localparam logic [19:0] DEPTH_W    = 20'(TLB_DEPTH);

    logic [tpt_pkg::DIR_BASE_W-1:0] dir_base_reg;
    logic                           a_valid_reg;
    logic                           a_valid_next;
    tpt_pkg::tpt_in_t               a_item_reg;
    logic [QS-1:0]                  a_quot_reg;
    logic                           accept;
    logic [41:0]                    slot_prod;
    logic [19:0]                    a_vpn;
    logic [19:0]                    slot_back;
    logic [19:0]                    slot_rem;
    logic [13:0]                    dir_word;

    function automatic logic [AW-1:0] wrap_word(input logic [13:0] word);
        logic [23:0] rem;
        logic [23:0] lim;
        rem = 24'(word);
        for (int k = 2; k >= 0; k--) begin
            lim = 24'(TABLE_MEM_WORDS) << k;
            if (rem >= lim) begin
                rem = rem - lim;
            end
        end
        return rem[AW-1:0];
    endfunction

    assign s_ready = !clearing && (!a_valid_reg || !full);
    assign accept  = s_valid && s_ready;
    assign push    = a_valid_reg && !full;

    assign slot_prod    = 42'(s_data.virt_addr[31:12]) * 42'(SLOT_RCP);
    assign a_vpn        = a_item_reg.virt_addr[31:12];
    assign slot_back    = 20'({{(20 - QS){1'b0}}, a_quot_reg} * DEPTH_W);
    assign slot_rem     = a_vpn - slot_back;
    assign dir_word     = {dir_base_reg, a_item_reg.virt_addr[31:22]};
    assign a_valid_next = accept || (a_valid_reg && full);

    always_comb begin
        push_op.kind   = tpt_pkg::tpt_req_t'(a_item_reg.req_type);
        push_op.vpn    = a_vpn;
        push_op.offset = a_item_reg.virt_addr[11:0];
        push_op.frame  = a_item_reg.insert_phys_addr[31:12];
        push_op.data   = a_item_reg.mem_data;
        push_slot      = slot_rem[SW-1:0];
        if (push_op.kind == tpt_pkg::REQ_WRITE) begin
            push_addr = wrap_word(a_item_reg.mem_word_addr);
        end else begin
            push_addr = wrap_word(dir_word);
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            dir_base_reg <= '0;
            a_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                dir_base_reg <= cfg_wr_data;
            end
            a_valid_reg <= a_valid_next;
        end
        if (accept) begin
            a_item_reg <= s_data;
            a_quot_reg <= slot_prod[SLOT_SHIFT +: QS];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tpt_back.sv
// Back end: TLB lookup and update, table memory access and two-level walk.
`timescale 1ns / 1ps
`default_nettype none

module tpt_back #(
    parameter int TLB_DEPTH       = tpt_pkg::TLB_DEPTH_DEF,
    parameter int TABLE_MEM_WORDS = tpt_pkg::TABLE_MEM_WORDS_DEF,
    localparam int SW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1,
    localparam int AW = $clog2(TABLE_MEM_WORDS)
) (
    input  wire logic              clk,
    input  wire logic              rstn,
    input  wire logic              q_valid,
    input  wire tpt_pkg::tpt_op_t  q_op,
    input  wire logic [SW-1:0]     q_slot,
    input  wire logic [AW-1:0]     q_addr,
    output logic                   q_pop,
    output logic                   clearing,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tpt_pkg::tpt_out_t      m_data
);

    localparam int          WW         = tpt_pkg::WALK_W;
    localparam int          TBL_L      = $clog2(TABLE_MEM_WORDS);
    localparam int          TBL_SHIFT  = WW + TBL_L;
    localparam logic [63:0] TBL_RCP_W  = ((64'd1 << TBL_SHIFT) + 64'(TABLE_MEM_WORDS) - 64'd1)
                                         / 64'(TABLE_MEM_WORDS);
    localparam logic [31:0] TBL_RCP    = TBL_RCP_W[31:0];
    localparam int          QW         = WW + 1 - TBL_L;
    localparam logic [WW-1:0] TBL_WORDS_W = WW'(TABLE_MEM_WORDS);
    localparam logic [SW-1:0] SLOT_LAST = SW'(TLB_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_DIR,
        ST_TADDR,
        ST_PTE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic        valid;
        logic [19:0] tag;
        logic [19:0] frame;
    } tlb_word_t;

    state_t             state_reg;
    state_t             state_next;
    logic [SW-1:0]      clr_cnt_reg;
    logic [SW-1:0]      clr_cnt_next;
    tpt_pkg::tpt_op_t   op_reg;
    tpt_pkg::tpt_op_t   op_next;
    logic [SW-1:0]      slot_reg;
    logic [SW-1:0]      slot_next;
    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      addr_next;
    logic [WW-1:0]      walk_reg;
    logic [WW-1:0]      walk_next;
    logic [QW-1:0]      quot_reg;
    logic [QW-1:0]      quot_next;
    tpt_pkg::tpt_out_t  res_reg;
    tpt_pkg::tpt_out_t  res_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    tpt_pkg::tpt_out_t  m_data_reg;
    tpt_pkg::tpt_out_t  m_data_next;

    tlb_word_t          tlb_mem [TLB_DEPTH];
    tlb_word_t          tlb_rdata_reg;
    logic [31:0]        tbl_mem [TABLE_MEM_WORDS];
    logic [31:0]        tbl_rdata_reg;

    logic               tlb_re;
    logic               tlb_we;
    logic [SW-1:0]      tlb_waddr;
    tlb_word_t          tlb_wdata;
    logic               tbl_re;
    logic               tbl_we;
    logic [AW-1:0]      tbl_raddr;
    logic               tlb_match;
    logic               entry_valid;
    logic [WW-1:0]      walk_addr;
    logic [WW+31:0]     quot_prod;
    logic [WW-1:0]      rem_prod;
    logic [AW-1:0]      tab_addr;
    logic               out_free;

    assign clearing    = (state_reg == ST_CLEAR);
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;
    assign out_free    = !m_valid_reg || m_ready;
    assign tlb_match   = tlb_rdata_reg.valid && (tlb_rdata_reg.tag == op_reg.vpn);
    assign entry_valid = tbl_rdata_reg[tpt_pkg::VALID_BIT];
    assign walk_addr   = {tbl_rdata_reg[31:12], op_reg.vpn[9:0]};
    assign quot_prod   = (WW + 32)'(walk_addr) * (WW + 32)'(TBL_RCP);
    assign rem_prod    = WW'({{(WW - QW){1'b0}}, quot_reg} * TBL_WORDS_W);
    assign tab_addr    = AW'(walk_reg - rem_prod);

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        op_next      = op_reg;
        slot_next    = slot_reg;
        addr_next    = addr_reg;
        walk_next    = walk_reg;
        quot_next    = quot_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        q_pop        = 1'b0;
        tlb_re       = 1'b0;
        tlb_we       = 1'b0;
        tlb_waddr    = slot_reg;
        tlb_wdata    = '0;
        tbl_re       = 1'b0;
        tbl_we       = 1'b0;
        tbl_raddr    = addr_reg;

        case (state_reg)
            ST_CLEAR: begin
                tlb_we       = 1'b1;
                tlb_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SLOT_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    tlb_re     = 1'b1;
                    op_next    = q_op;
                    slot_next  = q_slot;
                    addr_next  = q_addr;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                res_next   = '0;
                state_next = ST_RESP;
                case (op_reg.kind)
                    tpt_pkg::REQ_TRANSLATE: begin
                        if (tlb_match) begin
                            res_next.tlb_hit    = 1'b1;
                            res_next.translated = 1'b1;
                            res_next.phys_addr  = {tlb_rdata_reg.frame, op_reg.offset};
                        end else begin
                            tbl_re     = 1'b1;
                            state_next = ST_DIR;
                        end
                    end
                    tpt_pkg::REQ_WRITE: begin
                        tbl_we = 1'b1;
                    end
                    tpt_pkg::REQ_INSERT: begin
                        tlb_we          = 1'b1;
                        tlb_wdata.valid = 1'b1;
                        tlb_wdata.tag   = op_reg.vpn;
                        tlb_wdata.frame = op_reg.frame;
                    end
                    tpt_pkg::REQ_INVAL: begin
                        tlb_we = tlb_match;
                    end
                    default: begin
                    end
                endcase
            end
            ST_DIR: begin
                if (entry_valid) begin
                    walk_next  = walk_addr;
                    quot_next  = quot_prod[TBL_SHIFT +: QW];
                    state_next = ST_TADDR;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_TADDR: begin
                tbl_re     = 1'b1;
                tbl_raddr  = tab_addr;
                state_next = ST_PTE;
            end
            ST_PTE: begin
                if (entry_valid) begin
                    res_next.translated = 1'b1;
                    res_next.phys_addr  = {tbl_rdata_reg[31:12], op_reg.offset};
                    tlb_we              = 1'b1;
                    tlb_wdata.valid     = 1'b1;
                    tlb_wdata.tag       = op_reg.vpn;
                    tlb_wdata.frame     = tbl_rdata_reg[31:12];
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        slot_reg   <= slot_next;
        addr_reg   <= addr_next;
        walk_reg   <= walk_next;
        quot_reg   <= quot_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge clk) begin
        if (tlb_we) begin
            tlb_mem[tlb_waddr] <= tlb_wdata;
        end
        if (tlb_re) begin
            tlb_rdata_reg <= tlb_mem[q_slot];
        end
    end

    always_ff @(posedge clk) begin
        if (tbl_we) begin
            tbl_mem[addr_reg] <= op_reg.data;
        end
        if (tbl_re) begin
            tbl_rdata_reg <= tbl_mem[tbl_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tlb_page_table_translator.sv
// Top level of the MMU: direct-mapped TLB with a two-level page table walk.
//
// Requests arrive on the s_ channel (valid/ready, one transfer per request) and
// each request yields exactly one result transfer on the m_ channel, in order.
// Request types: translate, write a table memory word, insert a TLB entry,
// invalidate a matching TLB entry. cfg_wr_en/cfg_wr_data set the directory page.
// A request passes the front-end input stage and the two-entry queue, then the
// back end. The back end handles one request at a time: a synchronous TLB read
// and lookup, then on a translate miss the dependent directory read and, if
// that entry is valid, the table read of table memory, and last the result; it
// takes the next request from the queue once the result is in the output register.
// Reset clears the TLB valid bits in a sweep over all TLB_DEPTH entries, one
// entry a cycle, with s_ready low throughout. Table memory is not cleared.
// When the receiver stalls, the result holds in the output register, the
// back end waits to hand over its next result, and the front end keeps taking
// requests until its two-entry queue and input stage are full.
`timescale 1ns / 1ps
`default_nettype none

module tlb_page_table_translator #(
    parameter int TLB_DEPTH       = tpt_pkg::TLB_DEPTH_DEF,
    parameter int TABLE_MEM_WORDS = tpt_pkg::TABLE_MEM_WORDS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tpt_pkg::DIR_BASE_W-1:0]  cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire tpt_pkg::tpt_in_t                s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output tpt_pkg::tpt_out_t                    m_data
);

    localparam int SW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int AW = $clog2(TABLE_MEM_WORDS);
    localparam int QE = $bits(tpt_pkg::tpt_op_t) + SW + AW;

    logic              clearing;
    logic              full;
    logic              push;
    tpt_pkg::tpt_op_t  push_op;
    logic [SW-1:0]     push_slot;
    logic [AW-1:0]     push_addr;
    logic              q_pop;
    logic              q_valid;
    logic [QE-1:0]     q_data;
    tpt_pkg::tpt_op_t  q_op;
    logic [SW-1:0]     q_slot;
    logic [AW-1:0]     q_addr;

    assign {q_op, q_slot, q_addr} = q_data;

    tpt_front #(
        .TLB_DEPTH       (TLB_DEPTH),
        .TABLE_MEM_WORDS (TABLE_MEM_WORDS)
    ) u_front (
        .clk         (aclk),
        .rstn        (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .clearing    (clearing),
        .full        (full),
        .push        (push),
        .push_op     (push_op),
        .push_slot   (push_slot),
        .push_addr   (push_addr)
    );

    tpt_queue #(
        .WIDTH (QE)
    ) u_queue (
        .clk       (aclk),
        .rstn      (aresetn),
        .push      (push),
        .push_data ({push_op, push_slot, push_addr}),
        .full      (full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    tpt_back #(
        .TLB_DEPTH       (TLB_DEPTH),
        .TABLE_MEM_WORDS (TABLE_MEM_WORDS)
    ) u_back (
        .clk      (aclk),
        .rstn     (aresetn),
        .q_valid  (q_valid),
        .q_op     (q_op),
        .q_slot   (q_slot),
        .q_addr   (q_addr),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/tpt_checker.sv
// Port-level checks for the page table translator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tpt_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire tpt_pkg::tpt_out_t  m_data
);

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_hit_translates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.tlb_hit |-> m_data.translated)
        else $error("TLB hit without translation");

    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.translated |-> m_data.phys_addr == 32'd0 && !m_data.tlb_hit)
        else $error("untranslated result carries an address or hit");

    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |-> !s_ready)
        else $error("request taken during TLB clear");

endmodule

bind tlb_page_table_translator tpt_checker u_tpt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
